// ----- rtl/cc_cv_pid_duty_controller_macros.svh -----
// ----------------------------------------------------------------------------
// CC/CV PID duty controller assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CC_CV_PID_DUTY_CONTROLLER_MACROS_SVH
`define CC_CV_PID_DUTY_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// check b in the same cycle as a
`define CCPD_ASSERT_SAME(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error(msg);

// check b in the cycle after a
`define CCPD_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error(msg);

`else

`define CCPD_ASSERT_SAME(lbl, clk, rstn, a, b, msg)
`define CCPD_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)

`endif

`endif

// ----- rtl/ccpd_pkg.sv -----
// ----------------------------------------------------------------------------
// CC/CV PID duty controller package
// Field widths, register indexes, accumulator type and saturating add.
// ----------------------------------------------------------------------------
package ccpd_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int DUTY_BITS_DEF      = 9;

    localparam int ADC_W   = 12;
    localparam int THR_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int DUTY_W  = 9;
    localparam int ERR_W   = 13;
    localparam int ACC_W   = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // millivolt conversion: round(code * 5000 / 4096)
    localparam int MV_SCALE   = 5000;
    localparam int MV_SHIFT   = 12;
    localparam int MV_PROD_W  = 25;
    localparam int MV_W       = MV_PROD_W - MV_SHIFT;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CV_GAIN_P   = 3'd0,
        REG_CV_GAIN_I   = 3'd1,
        REG_CV_GAIN_D   = 3'd2,
        REG_CC_GAIN_P   = 3'd3,
        REG_CC_GAIN_I   = 3'd4,
        REG_ERROR_LIMIT = 3'd5,
        REG_DUTY_MIN    = 3'd6,
        REG_DUTY_MAX    = 3'd7
    } cfg_reg_t;

    localparam logic [ADC_W-1:0]  ERROR_LIMIT_RST = 12'd4095;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST    = 9'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST    = 9'd511;

    typedef struct packed {
        logic [THR_W-1:0] cv_threshold_mv;
        logic [ADC_W-1:0] avg_voltage_code;
        logic [ADC_W-1:0] current_target;
        logic [ADC_W-1:0] voltage_target;
        logic [ADC_W-1:0] current_sample;
        logic [ADC_W-1:0] voltage_sample;
        logic             restart;
    } tick_t;

    localparam int TICK_W = $bits(tick_t);

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ----- rtl/cc_cv_pid_duty_controller.sv -----
// ----------------------------------------------------------------------------
// CC/CV PID duty controller
// One control tick per request on s_*, one duty result per tick on m_*. Each
// tick checks the CC-to-CV switch on the averaged voltage, then runs one PID
// update (voltage loop in CV, current loop in CC) with 48-bit saturating
// integrator and duty accumulator, and returns the clamped integer duty.
// A request lands in the input register at the accepting edge; once the result
// register is free or being read, the state update loads into it and m_tvalid
// rises. One request is taken every cycle; a result held by m_tready low drops
// s_tready once both registers are full. The user must write gains on cfg_*
// only while idle, which the block does not enforce; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "cc_cv_pid_duty_controller_macros.svh"

module cc_cv_pid_duty_controller
    import ccpd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DUTY_BITS      = DUTY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // restart, voltage_sample, current_sample, voltage_target,
    // current_target, avg_voltage_code, cv_threshold_mv (low bit up)
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // duty results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // duty_level, in_cv_mode, switched_now (low bit up)
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam logic [DUTY_W-1:0] DUTY_MASK = DUTY_W'((1 << DUTY_BITS) - 1);

    // configuration registers
    logic [GAIN_W-1:0] cv_gain_p_reg, cv_gain_i_reg, cv_gain_d_reg;
    logic [GAIN_W-1:0] cc_gain_p_reg, cc_gain_i_reg;
    logic [ADC_W-1:0]  error_limit_reg;
    logic [DUTY_W-1:0] duty_min_reg, duty_max_reg;

    // input stage
    logic  in_vld_reg, in_vld_next;
    tick_t in_reg;

    // loop state
    logic                    cv_flag_reg, cv_flag_next;
    acc_t                    integ_reg, integ_next;
    acc_t                    duty_acc_reg, duty_acc_next;
    logic signed [ERR_W-1:0] last_err_reg, last_err_next;

    // result stage
    logic              out_vld_reg, out_vld_next;
    logic [DUTY_W-1:0] duty_out_reg, duty_out_next;
    logic              cv_out_reg, cv_out_next;
    logic              sw_out_reg, sw_out_next;

    logic advance;
    logic s_fire;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{(M_TDATA_W - DUTY_W - 2){1'b0}}, sw_out_reg, cv_out_reg, duty_out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_gain_p_reg   <= '0;
            cv_gain_i_reg   <= '0;
            cv_gain_d_reg   <= '0;
            cc_gain_p_reg   <= '0;
            cc_gain_i_reg   <= '0;
            error_limit_reg <= ERROR_LIMIT_RST;
            duty_min_reg    <= DUTY_MIN_RST;
            duty_max_reg    <= DUTY_MAX_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_CV_GAIN_P:   cv_gain_p_reg   <= cfg_data;
                REG_CV_GAIN_I:   cv_gain_i_reg   <= cfg_data;
                REG_CV_GAIN_D:   cv_gain_d_reg   <= cfg_data;
                REG_CC_GAIN_P:   cc_gain_p_reg   <= cfg_data;
                REG_CC_GAIN_I:   cc_gain_i_reg   <= cfg_data;
                REG_ERROR_LIMIT: error_limit_reg <= cfg_data[ADC_W-1:0];
                REG_DUTY_MIN:    duty_min_reg    <= cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX:    duty_max_reg    <= cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    // one PID tick
    always_comb begin
        logic                    cv0;
        acc_t                    integ0, duty0;
        logic signed [ERR_W-1:0] last0;
        logic [MV_PROD_W-1:0]    mv_prod;
        logic [MV_W-1:0]         mv;
        logic                    sw;
        logic                    cv1;
        logic [GAIN_W-1:0]       kp, ki, kd;
        logic [ADC_W-1:0]        fb, sp;
        logic signed [ERR_W-1:0] diff, lim, e;
        logic signed [ERR_W:0]   dd;
        logic signed [GAIN_W+ERR_W+1:0] p_d;
        logic signed [GAIN_W+ERR_W:0]   p_i, p_p;
        acc_t                    integ1, duty1, inner, duty2, hi, lo;

        cv0    = in_reg.restart ? 1'b0 : cv_flag_reg;
        integ0 = in_reg.restart ? '0 : integ_reg;
        duty0  = in_reg.restart ? '0 : duty_acc_reg;
        last0  = in_reg.restart ? '0 : last_err_reg;

        mv_prod = MV_PROD_W'(in_reg.avg_voltage_code) * MV_PROD_W'(MV_SCALE)
                + MV_PROD_W'(1 << (MV_SHIFT - 1));
        mv  = mv_prod[MV_PROD_W-1:MV_SHIFT];
        sw  = !cv0 && (THR_W'(mv) > in_reg.cv_threshold_mv);
        cv1 = cv0 || sw;
        if (sw) begin
            integ0 = '0;
        end

        if (cv1) begin
            kp = cv_gain_p_reg;
            ki = cv_gain_i_reg;
            kd = cv_gain_d_reg;
            sp = in_reg.voltage_target;
            fb = in_reg.voltage_sample;
        end else begin
            kp = cc_gain_p_reg;
            ki = cc_gain_i_reg;
            kd = '0;
            sp = in_reg.current_target;
            fb = in_reg.current_sample;
        end

        diff = $signed({1'b0, sp}) - $signed({1'b0, fb});
        dd   = {diff[ERR_W-1], diff} - {last0[ERR_W-1], last0};
        lim  = $signed({1'b0, error_limit_reg});
        e    = diff;
        if (diff > lim) begin
            e = lim;
        end else if (diff < -lim) begin
            e = -lim;
        end

        p_d = $signed({1'b0, kd}) * dd;
        p_i = $signed({1'b0, ki}) * e;
        p_p = $signed({1'b0, kp}) * e;

        duty1  = sat_add(duty0, ACC_W'(p_d));
        integ1 = sat_add(integ0, ACC_W'(p_i));
        inner  = sat_add(ACC_W'(p_p), integ1);
        duty2  = sat_add(duty1, inner);

        hi = $signed(ACC_W'(duty_max_reg) << GAIN_FRAC_BITS);
        lo = $signed(ACC_W'(duty_min_reg) << GAIN_FRAC_BITS);
        if (duty2 >= hi) begin
            duty2 = hi;
        end else if (duty2 <= lo) begin
            duty2 = lo;
        end

        cv_flag_next  = cv1;
        integ_next    = integ1;
        duty_acc_next = duty2;
        last_err_next = e;
        duty_out_next = duty2[GAIN_FRAC_BITS +: DUTY_W] & DUTY_MASK;
        cv_out_next   = cv1;
        sw_out_next   = sw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            cv_flag_reg  <= 1'b0;
            integ_reg    <= '0;
            duty_acc_reg <= '0;
            last_err_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                cv_flag_reg  <= cv_flag_next;
                integ_reg    <= integ_next;
                duty_acc_reg <= duty_acc_next;
                last_err_reg <= last_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= tick_t'(s_tdata[TICK_W-1:0]);
        end
        if (advance) begin
            duty_out_reg <= duty_out_next;
            cv_out_reg   <= cv_out_next;
            sw_out_reg   <= sw_out_next;
        end
    end

    `CCPD_ASSERT_SAME(a_switch_in_cv, aclk, aresetn,
        out_vld_reg && sw_out_reg, cv_out_reg, "switch reported outside CV mode")
    `CCPD_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, !advance,
        $stable(duty_acc_reg) && $stable(integ_reg) && $stable(cv_flag_reg),
        "loop state moved without a tick")
    `CCPD_ASSERT_NEXT(a_duty_in_range, aclk, aresetn,
        advance && (duty_min_reg <= duty_max_reg),
        (duty_acc_reg <= $signed(ACC_W'(duty_max_reg) << GAIN_FRAC_BITS)) &&
        (duty_acc_reg >= $signed(ACC_W'(duty_min_reg) << GAIN_FRAC_BITS)),
        "duty accumulator outside clamp")
    `CCPD_ASSERT_SAME(a_ready_when_free, aclk, aresetn,
        !in_vld_reg || !out_vld_reg, s_tready, "input stalled with free space")

endmodule
